@@ design/imh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package imh_pkg;

	localparam int NODES  = 1024;
	localparam int NODE_W = 10;
	localparam int KEY_W  = 48;
	localparam int SLOT_W = 11;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_POP    = 1'b1;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_EMPTY     = 2'd1;
	localparam logic [1:0] STATUS_NOT_LESS  = 2'd2;

	typedef struct packed {
		logic              opcode;
		logic [NODE_W-1:0] node_id;
		logic [KEY_W-1:0]  key;
	} cmd_t;

	typedef struct packed {
		logic [NODE_W-1:0] out_node;
		logic [KEY_W-1:0]  out_key;
		logic [1:0]        status;
		logic [SLOT_W-1:0] count;
	} rsp_t;

	// Word of the per-node memory: heap slot (0 when absent) and key
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [KEY_W-1:0]  key;
	} node_word_t;

endpackage

`default_nettype wire

@@ design/indexed_min_heap.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Payload        | Handshake
// cmd     | in  | imh_pkg::cmd_t | cmd_valid / cmd_stall
// rsp     | out | imh_pkg::rsp_t | rsp_valid / rsp_stall
//
// One item at a time. Update reads the node word, rises level by level and ends with a write
// (an update whose key is not less is ignored). Pop reads the top, sinks level by level,
// skipping the read of an absent right child, and ends with a write (an empty pop skips all);
// each level costs dependent reads of the slot memory and the node memory, one read port each.
// Reset starts a clearing pass over all 1024 entries of the node memory; cmd_stall is high meanwhile.
// A finished result waits in the rsp register; the sequencer waits only if the next is ready first.

module indexed_min_heap (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire imh_pkg::cmd_t cmd,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	output imh_pkg::rsp_t      rsp,
	output logic               rsp_valid,
	input  wire logic          rsp_stall
);
	import imh_pkg::*;

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_UCHK  = 5'd2;
	localparam logic [4:0] S_UPA   = 5'd3;
	localparam logic [4:0] S_UPB   = 5'd4;
	localparam logic [4:0] S_UPC   = 5'd5;
	localparam logic [4:0] S_UPFIN = 5'd6;
	localparam logic [4:0] S_PA    = 5'd7;
	localparam logic [4:0] S_PB    = 5'd8;
	localparam logic [4:0] S_PC    = 5'd9;
	localparam logic [4:0] S_PD    = 5'd10;
	localparam logic [4:0] S_DNA   = 5'd11;
	localparam logic [4:0] S_DNB   = 5'd12;
	localparam logic [4:0] S_DNC   = 5'd13;
	localparam logic [4:0] S_DND   = 5'd14;
	localparam logic [4:0] S_DNE   = 5'd15;
	localparam logic [4:0] S_DNFIN = 5'd16;
	localparam logic [4:0] S_DONE  = 5'd17;

	// memories
	node_word_t        node_mem [0:NODES-1];
	logic [NODE_W-1:0] slot_mem [0:NODES-1];

	logic              nm_re, nm_we, hm_re, hm_we;
	logic [NODE_W-1:0] nm_ra, nm_wa, hm_ra, hm_wa, hm_wd;
	node_word_t        nm_wd;
	node_word_t        nm_rd_q;
	logic [NODE_W-1:0] hm_rd_q;

	// control and payload registers
	logic [4:0]        state_q, state_d;
	logic [NODE_W-1:0] clr_q;
	logic [SLOT_W-1:0] cnt_q;
	logic [SLOT_W-1:0] cur_slot_q, child_q, best_slot_q;
	logic [NODE_W-1:0] cur_node_q, par_node_q, lnode_q, rnode_q, best_node_q, top_node_q;
	logic [KEY_W-1:0]  cur_key_q, lkey_q, best_key_q, top_key_q;
	logic              has_r_q;
	rsp_t              res_q;

	logic [SLOT_W-1:0] par_slot, child_c, par_slot_m1, cur_slot_m1, child_m1, cnt_m1;
	logic              cmd_acc, rsp_free;

	assign cmd_acc     = cmd_valid && !cmd_stall;
	assign cmd_stall   = (state_q != S_IDLE);
	assign rsp_free    = !rsp_valid || !rsp_stall;
	assign par_slot    = cur_slot_q >> 1;
	assign par_slot_m1 = par_slot - SLOT_W'(1);
	assign cur_slot_m1 = cur_slot_q - SLOT_W'(1);
	assign child_c     = {cur_slot_q[SLOT_W-2:0], 1'b0};
	assign child_m1    = child_c - SLOT_W'(1);
	assign cnt_m1      = cnt_q - SLOT_W'(1);

	// memory ports and next state
	always_comb begin
		state_d = state_q;
		nm_re = 1'b0; nm_ra = '0;
		nm_we = 1'b0; nm_wa = '0; nm_wd = '0;
		hm_re = 1'b0; hm_ra = '0;
		hm_we = 1'b0; hm_wa = '0; hm_wd = '0;
		unique case (state_q)
			S_CLR: begin
				nm_we = 1'b1;
				nm_wa = clr_q;
				if (clr_q == NODE_W'(NODES - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cmd_acc) begin
					if (cmd.opcode == OP_UPDATE) begin
						nm_re = 1'b1;
						nm_ra = cmd.node_id;
						state_d = S_UCHK;
					end else if (cnt_q == '0) begin
						state_d = S_DONE;
					end else begin
						hm_re = 1'b1;
						state_d = S_PA;
					end
				end
			end
			S_UCHK: begin
				if (nm_rd_q.slot == '0) begin
					if (cnt_q < SLOT_W'(NODES)) begin
						state_d = S_UPA;
					end else begin
						nm_we = 1'b1;
						nm_wa = cur_node_q;
						nm_wd = '{slot: '0, key: cur_key_q};
						state_d = S_DONE;
					end
				end else if (cur_key_q < nm_rd_q.key) begin
					state_d = S_UPA;
				end else begin
					state_d = S_DONE;
				end
			end
			S_UPA: begin
				if (cur_slot_q == SLOT_W'(1)) begin
					state_d = S_UPFIN;
				end else begin
					hm_re = 1'b1;
					hm_ra = par_slot_m1[NODE_W-1:0];
					state_d = S_UPB;
				end
			end
			S_UPB: begin
				nm_re = 1'b1;
				nm_ra = hm_rd_q;
				state_d = S_UPC;
			end
			S_UPC: begin
				if (cur_key_q < nm_rd_q.key) begin
					hm_we = 1'b1;
					hm_wa = cur_slot_m1[NODE_W-1:0];
					hm_wd = par_node_q;
					nm_we = 1'b1;
					nm_wa = par_node_q;
					nm_wd = '{slot: cur_slot_q, key: nm_rd_q.key};
					state_d = S_UPA;
				end else begin
					state_d = S_UPFIN;
				end
			end
			S_UPFIN, S_DNFIN: begin
				hm_we = 1'b1;
				hm_wa = cur_slot_m1[NODE_W-1:0];
				hm_wd = cur_node_q;
				nm_we = 1'b1;
				nm_wa = cur_node_q;
				nm_wd = '{slot: cur_slot_q, key: cur_key_q};
				state_d = S_DONE;
			end
			S_PA: begin
				nm_re = 1'b1;
				nm_ra = hm_rd_q;
				state_d = S_PB;
			end
			S_PB: begin
				nm_we = 1'b1;
				nm_wa = top_node_q;
				nm_wd = '{slot: '0, key: nm_rd_q.key};
				if (cnt_q == SLOT_W'(1)) begin
					state_d = S_DONE;
				end else begin
					hm_re = 1'b1;
					hm_ra = cnt_m1[NODE_W-1:0];
					state_d = S_PC;
				end
			end
			S_PC: begin
				nm_re = 1'b1;
				nm_ra = hm_rd_q;
				state_d = S_PD;
			end
			S_PD: state_d = S_DNA;
			S_DNA: begin
				if (cur_slot_q > (cnt_q >> 1)) begin
					state_d = S_DNFIN;
				end else begin
					hm_re = 1'b1;
					hm_ra = child_m1[NODE_W-1:0];
					state_d = S_DNB;
				end
			end
			S_DNB: begin
				nm_re = 1'b1;
				nm_ra = hm_rd_q;
				if (child_q < cnt_q) begin
					hm_re = 1'b1;
					hm_ra = child_q[NODE_W-1:0];
				end
				state_d = S_DNC;
			end
			S_DNC: begin
				if (has_r_q) begin
					nm_re = 1'b1;
					nm_ra = hm_rd_q;
					state_d = S_DND;
				end else begin
					state_d = S_DNE;
				end
			end
			S_DND: state_d = S_DNE;
			S_DNE: begin
				if (best_key_q < cur_key_q) begin
					hm_we = 1'b1;
					hm_wa = cur_slot_m1[NODE_W-1:0];
					hm_wd = best_node_q;
					nm_we = 1'b1;
					nm_wa = best_node_q;
					nm_wd = '{slot: cur_slot_q, key: best_key_q};
					state_d = S_DNA;
				end else begin
					state_d = S_DNFIN;
				end
			end
			S_DONE: begin
				if (rsp_free) state_d = S_IDLE;
			end
			default: state_d = S_CLR;
		endcase
	end

	// memory arrays with registered read
	always_ff @(posedge clk) begin
		if (nm_we) node_mem[nm_wa] <= nm_wd;
		if (nm_re) nm_rd_q <= node_mem[nm_ra];
		if (hm_we) slot_mem[hm_wa] <= hm_wd;
		if (hm_re) hm_rd_q <= slot_mem[hm_ra];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			cnt_q     <= '0;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) clr_q <= clr_q + NODE_W'(1);
			if (state_q == S_UCHK && nm_rd_q.slot == '0 && cnt_q < SLOT_W'(NODES))
				cnt_q <= cnt_q + SLOT_W'(1);
			if (state_q == S_PB && cnt_q == SLOT_W'(1)) cnt_q <= '0;
			if (state_q == S_PC) cnt_q <= cnt_m1;
			// drop a taken beat, load the finished one
			if (state_q == S_DONE && rsp_free) rsp_valid <= 1'b1;
			else if (!rsp_stall) rsp_valid <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cur_node_q <= cmd.node_id;
				cur_key_q  <= cmd.key;
				res_q      <= '{out_node: '0, out_key: '0, status: STATUS_EMPTY, count: '0};
			end
			S_UCHK: begin
				res_q.out_node <= cur_node_q;
				res_q.status   <= STATUS_OK;
				res_q.out_key  <= cur_key_q;
				res_q.count    <= cnt_q;
				if (nm_rd_q.slot == '0) begin
					cur_slot_q <= cnt_q + SLOT_W'(1);
				end else if (cur_key_q < nm_rd_q.key) begin
					cur_slot_q <= nm_rd_q.slot;
				end else begin
					res_q.out_key <= nm_rd_q.key;
					res_q.status  <= STATUS_NOT_LESS;
				end
			end
			S_UPB: par_node_q <= hm_rd_q;
			S_UPC: begin
				if (cur_key_q < nm_rd_q.key) cur_slot_q <= par_slot;
			end
			S_UPFIN: begin
				res_q.count <= cnt_q;
			end
			S_PA: top_node_q <= hm_rd_q;
			S_PB: begin
				top_key_q <= nm_rd_q.key;
				res_q     <= '{out_node: top_node_q, out_key: nm_rd_q.key,
					status: STATUS_OK, count: '0};
			end
			S_PC: cur_node_q <= hm_rd_q;
			S_PD: begin
				cur_key_q  <= nm_rd_q.key;
				cur_slot_q <= SLOT_W'(1);
			end
			S_DNA: child_q <= child_c;
			S_DNB: begin
				lnode_q <= hm_rd_q;
				has_r_q <= child_q < cnt_q;
			end
			S_DNC: begin
				lkey_q      <= nm_rd_q.key;
				rnode_q     <= hm_rd_q;
				best_node_q <= lnode_q;
				best_key_q  <= nm_rd_q.key;
				best_slot_q <= child_q;
			end
			S_DND: begin
				if (nm_rd_q.key < lkey_q) begin
					best_node_q <= rnode_q;
					best_key_q  <= nm_rd_q.key;
					best_slot_q <= child_q + SLOT_W'(1);
				end
			end
			S_DNE: begin
				if (best_key_q < cur_key_q) cur_slot_q <= best_slot_q;
			end
			S_DNFIN: begin
				res_q <= '{out_node: top_node_q, out_key: top_key_q,
					status: STATUS_OK, count: cnt_q};
			end
			S_DONE: begin
				if (rsp_free) rsp <= res_q;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ design/imh_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module imh_chk (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire imh_pkg::cmd_t cmd,
	input wire logic          cmd_valid,
	input wire logic          cmd_stall,
	input wire imh_pkg::rsp_t rsp,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall
);
	import imh_pkg::*;

	// one command at a time: busy after every accepted beat
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command taken while previous one in flight");

	// an empty pop reports an empty heap and no node
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STATUS_EMPTY |->
			rsp.count == '0 && rsp.out_node == '0 && rsp.out_key == '0)
		else $error("empty pop result malformed");

	// count never exceeds capacity and status is a defined code
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.count <= SLOT_W'(NODES) && rsp.status != 2'd3)
		else $error("result count or status out of range");

	// stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result beat changed");

endmodule

bind indexed_min_heap imh_chk u_imh_chk (.*);

`default_nettype wire

@@ bench/indexed_min_heap_test.sv @@
`timescale 1ns / 1ps

module indexed_min_heap_test;
	import imh_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	cmd_t cmd = '0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	rsp_t rsp;
	logic rsp_valid;
	logic rsp_stall = 1'b0;

	// heap predictor state
	logic [NODE_W-1:0] heap_arr [NODES];
	logic [SLOT_W-1:0] slot_arr [NODES];
	logic [KEY_W-1:0]  key_arr [NODES];
	int unsigned       heap_n;

	rsp_t expected_rsps [$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;

	indexed_min_heap DUT (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall), .rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
	);

	always #5 clk = ~clk;

	// bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [KEY_W-1:0] key_of_slot(int unsigned s);
		return key_arr[heap_arr[s-1]];
	endfunction

	function automatic void put_slot(int unsigned s, logic [NODE_W-1:0] nd);
		heap_arr[s-1] = nd;
		slot_arr[nd] = s[SLOT_W-1:0];
	endfunction

	function automatic void swap_slots(int unsigned a, int unsigned b);
		logic [NODE_W-1:0] na, nb;
		na = heap_arr[a-1];
		nb = heap_arr[b-1];
		put_slot(a, nb);
		put_slot(b, na);
	endfunction

	function automatic void sift_up(int unsigned s);
		while (s > 1 && key_of_slot(s) < key_of_slot(s/2)) begin
			swap_slots(s, s/2);
			s = s/2;
		end
	endfunction

	function automatic void sift_down(int unsigned s);
		int unsigned c;
		while (s <= heap_n/2) begin
			c = 2*s;
			if (c+1 <= heap_n && key_of_slot(c+1) < key_of_slot(c))
				c++;
			if (key_of_slot(c) < key_of_slot(s)) begin
				swap_slots(s, c);
				s = c;
			end else
				break;
		end
	endfunction

	function automatic rsp_t heap_predict(cmd_t c);
		rsp_t r;
		logic [NODE_W-1:0] top, nd;
		r = '0;
		nd = c.node_id;
		if (c.opcode == OP_POP) begin
			if (heap_n == 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				top = heap_arr[0];
				r.out_node = top;
				r.out_key = key_arr[top];
				slot_arr[top] = '0;
				if (heap_n > 1) begin
					top = heap_arr[heap_n-1];
					heap_n--;
					put_slot(1, top);
					sift_down(1);
				end else
					heap_n = 0;
			end
		end else begin
			r.out_node = nd;
			if (slot_arr[nd] == 0) begin
				key_arr[nd] = c.key;
				if (heap_n < NODES) begin
					heap_n++;
					put_slot(heap_n, nd);
					sift_up(heap_n);
				end
				r.out_key = c.key;
			end else if (c.key < key_arr[nd]) begin
				key_arr[nd] = c.key;
				sift_up(slot_arr[nd]);
				r.out_key = c.key;
			end else begin
				r.out_key = key_arr[nd];
				r.status = STATUS_NOT_LESS;
			end
		end
		r.count = heap_n[SLOT_W-1:0];
		return r;
	endfunction

	// receiver stall: random idling or a counted hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp_stall <= 1'b1;
		end else
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected result %h", $time, rsp);
				errors++;
			end else begin
				e = expected_rsps.pop_front();
				if (rsp.out_node !== e.out_node) begin
					$display("%0t: out_node exp %h got %h", $time, e.out_node, rsp.out_node);
					errors++;
				end
				if (rsp.out_key !== e.out_key) begin
					$display("%0t: out_key exp %h got %h", $time, e.out_key, rsp.out_key);
					errors++;
				end
				if (rsp.status !== e.status) begin
					$display("%0t: status exp %h got %h", $time, e.status, rsp.status);
					errors++;
				end
				if (rsp.count !== e.count) begin
					$display("%0t: count exp %h got %h", $time, e.count, rsp.count);
					errors++;
				end
			end
		end
	end

	// offer one beat; valid stays high until the next send or drain replaces it
	task automatic send_cmd(logic op, logic [NODE_W-1:0] nd, logic [KEY_W-1:0] k);
		cmd_t c;
		c.opcode = op;
		c.node_id = nd;
		c.key = k;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		expected_rsps.push_back(heap_predict(c));
	endtask

	task automatic drain_rsps();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_rsps.size() != 0);
	endtask

	function automatic logic [KEY_W-1:0] rand_key();
		logic [KEY_W-1:0] k;
		k = KEY_W'({$urandom, $urandom});
		case ($urandom_range(3))
			0: k = k & 48'hFF;
			1: k = '0;
			2: k = '1 - $urandom_range(3);
			default: ;
		endcase
		return k;
	endfunction

	task automatic test_directed();
		send_cmd(OP_POP, 10'd5, 48'd7);
		send_cmd(OP_UPDATE, 10'd0, '1);
		send_cmd(OP_UPDATE, 10'd1023, '0);
		send_cmd(OP_UPDATE, 10'd512, 48'h800000000000);
		send_cmd(OP_UPDATE, 10'd1023, 48'd3);
		send_cmd(OP_UPDATE, 10'd0, '1);
		send_cmd(OP_UPDATE, 10'd0, 48'h7FFFFFFFFFFF);
		send_cmd(OP_UPDATE, 10'd7, 48'd100);
		send_cmd(OP_UPDATE, 10'd8, 48'd100);
		send_cmd(OP_UPDATE, 10'd9, 48'd100);
		send_cmd(OP_UPDATE, 10'd341, 48'h555555555555);
		send_cmd(OP_UPDATE, 10'd682, 48'hAAAAAAAAAAAA);
		send_cmd(OP_UPDATE, 10'd512, '0);
		for (int i = 0; i < 11; i++)
			send_cmd(OP_POP, 10'(i), '1);
		drain_rsps();
	endtask

	// mostly inserts and decreases on a pool of nodes, some pops
	task automatic test_random(int n);
		logic op;
		logic [NODE_W-1:0] nd;
		logic [KEY_W-1:0] k;
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(99) < 35) ? OP_POP : OP_UPDATE;
			nd = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(63));
			k = rand_key();
			if (op == OP_UPDATE && slot_arr[nd] != 0 && $urandom_range(1))
				k = key_arr[nd] - $urandom_range(1, 1000);
			send_cmd(op, nd, k);
		end
	endtask

	task automatic test_backpressure();
		hold_cycles = 300;
		for (int i = 0; i < 20; i++)
			send_cmd(OP_UPDATE, 10'($urandom), rand_key());
		drain_rsps();
	endtask

	// grow the heap over spread nodes, then pop it down past empty
	task automatic test_full_heap();
		for (int i = 0; i < NODES; i += 8)
			send_cmd(OP_UPDATE, 10'(i), rand_key());
		drain_rsps();
		for (int i = 0; i < 130; i++)
			send_cmd(OP_POP, '0, '0);
		drain_rsps();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		heap_n = 0;
		for (int i = 0; i < NODES; i++) begin
			heap_arr[i] = '0;
			slot_arr[i] = '0;
			key_arr[i] = '0;
		end
		@(posedge clk);
		test_directed();
		send_idle_pct = 22;
		recv_idle_pct = 85;
		test_random(280);
		drain_rsps();
		test_backpressure();
		send_idle_pct = 85;
		recv_idle_pct = 22;
		test_random(220);
		drain_rsps();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(150);
		drain_rsps();
		test_full_heap();
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
